[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define TDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define TDS_ASSERT(lbl, clk, rst_n, prop)
`define TDS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hw/rtl/tds_pkg.sv]
`default_nettype none
package tds_pkg;
  localparam int MaxRows = 64;
  localparam int RowW    = $clog2(MaxRows);
  localparam int CntW    = $clog2(MaxRows + 1);
  localparam int DivSteps = 48;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroPiv  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic signed [31:0] lower;
    logic signed [31:0] main;
    logic signed [31:0] upper;
    logic signed [31:0] rhs;
    logic               last;
  } row_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_U, S_MUL_R, S_PIVOT, S_DIVGO, S_DIVWAIT, S_STORE,
    S_BS_READ, S_BS_MUL, S_BS_OUT
  } back_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'sh7fffffff;
    if (x < -50'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Q16.16 product rescale, round half up
  function automatic logic signed [47:0] qrnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/tds_div.sv]
`default_nettype none
module tds_div import tds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire div_req_t           req_i,
  output logic                    busy_o,
  output logic signed [31:0]      quot_o
);
  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [31:0]         rem_q, rem_d;
  logic [47:0]         quo_q, quo_d;
  logic [32:0]         den_q, den_d;
  logic                neg_q, neg_d;
  logic [32:0]         rem_sh;
  logic [33:0]         diff;
  logic [31:0]         num_mag;

  always_comb begin
    num_mag = req_i.num[31] ? 32'(-req_i.num) : req_i.num;
    rem_sh  = {rem_q, quo_q[47]};
    diff    = {1'b0, rem_sh} - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivSteps);
      rem_d  = '0;
      quo_d  = {num_mag, 16'd0};
      den_d  = req_i.den[31] ? 33'(-34'(req_i.den)) : {1'b0, req_i.den};
      neg_d  = req_i.num[31] ^ req_i.den[31];
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (!neg_q) quot_o = (quo_q > 48'h7fffffff) ? 32'sh7fffffff : quo_q[31:0];
    else        quot_o = (quo_q > 48'h80000000) ? 32'sh80000000 : 32'(-quo_q);
  end

  assign busy_o = busy_q;
endmodule
`default_nettype wire

[hw/rtl/tds_front.sv]
`default_nettype none
module tds_front import tds_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire row_t row_i,
  output logic      row_valid_o,
  output row_t      row_o,
  input  wire logic row_take_i
);
  row_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full        = cnt_q == 2'd2;
  assign row_valid_o = cnt_q != 2'd0;
  assign row_o       = fifo_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = row_take_i && row_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= !wr_q;
      if (rd_en) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_q] <= row_i;
  end
endmodule
`default_nettype wire

[hw/rtl/tds_back.sv]
`default_nettype none
module tds_back import tds_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         row_valid_i,
  input  wire row_t         row_i,
  output logic              row_take_o,
  output logic              out_valid_o,
  input  wire logic         out_pop_i,
  output logic signed [31:0] solution_value_o,
  output logic [RowW-1:0]   row_index_o,
  output logic              final_result_o,
  output logic [1:0]        status_o
);
  back_state_e state_q, state_d;
  row_t               row_q;
  logic [CntW-1:0]    cnt_q;
  logic [1:0]         flags_q;
  logic signed [31:0] prev_u_q, prev_r_q, piv_q, num_q, x_q;
  logic signed [63:0] prod_q;
  logic               zpiv_q, first_q;
  logic [RowW-1:0]    idx_q;
  logic [63:0]        mem_q [MaxRows];
  logic [63:0]        rd_q;
  logic               out_valid_q;
  logic signed [31:0] sol_q;
  logic [RowW-1:0]    oidx_q;
  logic               ofinal_q;
  logic [1:0]         ostat_q;

  div_req_t           req_u, req_r;
  logic               busy_u, busy_r;
  logic signed [31:0] quot_u, quot_r;
  logic               full_rows, mem_we, div_start, out_load;
  logic signed [31:0] rd_u, rd_r, x_new, mul_a, mul_b;

  assign full_rows = cnt_q == CntW'(MaxRows);
  assign rd_u = rd_q[63:32];
  assign rd_r = rd_q[31:0];

  tds_div u_div_upper (.clk_i, .rst_ni, .req_i(req_u), .busy_o(busy_u), .quot_o(quot_u));
  tds_div u_div_rhs   (.clk_i, .rst_ni, .req_i(req_r), .busy_o(busy_r), .quot_o(quot_r));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (row_valid_i) begin
        if (full_rows)        state_d = row_i.last ? S_BS_READ : S_IDLE;
        else if (cnt_q == '0) state_d = S_DIVGO;
        else                  state_d = S_MUL_U;
      end
      S_MUL_U:   state_d = S_MUL_R;
      S_MUL_R:   state_d = S_PIVOT;
      S_PIVOT:   state_d = S_DIVGO;
      S_DIVGO:   state_d = (piv_q == '0) ? S_STORE : S_DIVWAIT;
      S_DIVWAIT: if (!busy_u && !busy_r) state_d = S_STORE;
      S_STORE:   state_d = row_q.last ? S_BS_READ : S_IDLE;
      S_BS_READ: state_d = S_BS_MUL;
      S_BS_MUL:  state_d = S_BS_OUT;
      S_BS_OUT:  if (!out_valid_q) state_d = (idx_q == '0) ? S_IDLE : S_BS_READ;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    row_take_o = state_q == S_IDLE;
    div_start  = (state_q == S_DIVGO) && (piv_q != '0);
    mem_we     = state_q == S_STORE;
    out_load   = (state_q == S_BS_OUT) && !out_valid_q;
    req_u      = '{start: div_start, num: row_q.upper, den: piv_q};
    req_r      = '{start: div_start, num: num_q, den: piv_q};
    mul_a      = (state_q == S_BS_MUL) ? rd_u : row_q.lower;
    mul_b      = (state_q == S_BS_MUL) ? x_q : ((state_q == S_MUL_U) ? prev_u_q : prev_r_q);
    x_new      = first_q ? rd_r : sat32(50'(rd_r) - 50'(qrnd(prod_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)       out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
      if (state_q == S_IDLE && row_valid_i && full_rows) flags_q[1] <= 1'b1;
      if (state_q == S_DIVGO && piv_q == '0)             flags_q[0] <= 1'b1;
      if (mem_we) cnt_q <= cnt_q + 1'b1;
      if (out_load && idx_q == '0) begin
        cnt_q   <= '0;
        flags_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        row_q   <= row_i;
        piv_q   <= row_i.main;
        num_q   <= row_i.rhs;
        first_q <= 1'b1;
        idx_q   <= RowW'(MaxRows - 1);
      end
      S_MUL_U: prod_q <= mul_a * mul_b;
      S_MUL_R: begin
        piv_q  <= sat32(50'(row_q.main) - 50'(qrnd(prod_q)));
        prod_q <= mul_a * mul_b;
      end
      S_PIVOT: num_q <= sat32(50'(row_q.rhs) - 50'(qrnd(prod_q)));
      S_DIVGO: zpiv_q <= piv_q == '0;
      S_STORE: begin
        prev_u_q <= zpiv_q ? '0 : quot_u;
        prev_r_q <= zpiv_q ? '0 : quot_r;
        idx_q    <= cnt_q[RowW-1:0];
      end
      S_BS_READ: rd_q <= mem_q[idx_q];
      S_BS_MUL:  prod_q <= mul_a * mul_b;
      S_BS_OUT: if (out_load) begin
        x_q      <= x_new;
        sol_q    <= x_new;
        oidx_q   <= idx_q;
        ofinal_q <= idx_q == '0;
        ostat_q  <= flags_q[1] ? StatusOverflow : (flags_q[0] ? StatusZeroPiv : StatusOk);
        first_q  <= 1'b0;
        idx_q    <= idx_q - 1'b1;
      end
      default: ;
    endcase
    if (mem_we) mem_q[cnt_q[RowW-1:0]] <= zpiv_q ? 64'd0 : {quot_u, quot_r};
  end

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = sol_q;
  assign row_index_o      = oidx_q;
  assign final_result_o   = ofinal_q;
  assign status_o         = ostat_q;
endmodule
`default_nettype wire

[hw/rtl/tridiagonal_system_solver.sv]
// Forward sweep: two 48-step dividers run in parallel on each nonzero pivot.
// A row beyond 64 is dropped. Two rows can be queued ahead of the sweep.
// Back substitution: highest row first, each result held until popped, in a
// single result register.
// Reset (rst_ni low, asynchronous) empties the queues and clears row count and error flags.
`default_nettype none
`include "assert_macros.svh"
module tridiagonal_system_solver import tds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] lower_coeff_i,
  input  wire logic signed [31:0] main_coeff_i,
  input  wire logic signed [31:0] upper_coeff_i,
  input  wire logic signed [31:0] rhs_value_i,
  input  wire logic               last_row_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      solution_value_o,
  output logic [5:0]              row_index_o,
  output logic                    final_result_o,
  output logic [1:0]              status_o
);
  row_t in_row, q_row;
  logic q_valid, q_take, out_valid;
  logic popped;
  logic [5:0] row_below;

  assign in_row = '{lower: lower_coeff_i, main: main_coeff_i, upper: upper_coeff_i,
                    rhs: rhs_value_i, last: last_row_i};

  tds_front u_front (
    .clk_i, .rst_ni, .push, .full, .row_i(in_row),
    .row_valid_o(q_valid), .row_o(q_row), .row_take_i(q_take)
  );

  tds_back u_back (
    .clk_i, .rst_ni, .row_valid_i(q_valid), .row_i(q_row), .row_take_o(q_take),
    .out_valid_o(out_valid), .out_pop_i(pop), .solution_value_o,
    .row_index_o, .final_result_o, .status_o
  );

  assign empty = !out_valid;

  // non-final beat popped; the next one must be the row below
  assign popped    = !empty && pop && !final_result_o;
  assign row_below = row_index_o - 6'd1;

  `TDS_ASSERT(a_final_row0, clk_i, rst_ni, (!empty && final_result_o) |-> row_index_o == '0)
  `TDS_ASSERT_NEVER(a_status_code, clk_i, rst_ni, !empty && status_o == 2'd3)
  `TDS_ASSERT(a_next_row_down, clk_i, rst_ni, popped |=> (empty || row_index_o == $past(row_below)))
endmodule
`default_nettype wire

[verif/tridiagonal_system_solver_checker.sv]
module tridiagonal_system_solver_checker import tds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] lower_coeff_i,
  input  logic signed [31:0] main_coeff_i,
  input  logic signed [31:0] upper_coeff_i,
  input  logic signed [31:0] rhs_value_i,
  input  logic               last_row_i,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] solution_value_o,
  input  logic [5:0]         row_index_o,
  input  logic               final_result_o,
  input  logic [1:0]         status_o,
  output int                 fail_count,
  output int                 solutions_pending
);
  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         row;
    logic               fin;
    logic [1:0]         status;
  } solution_t;

  solution_t          solution_q[$];
  logic signed [31:0] sweep_upper[MaxRows];
  logic signed [31:0] sweep_rhs[MaxRows];
  int                 rows_held;
  logic               pivot_zero, rows_dropped;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // round half up: arithmetic shift floors
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
    if (d == 0) return 0;
    return clamp32((n * 64'sd65536) / d);
  endfunction

  task automatic sweep_row();
    logic signed [63:0] piv, num, x;
    logic [1:0]         st;
    if (rows_held < MaxRows) begin
      piv = main_coeff_i;
      num = rhs_value_i;
      if (rows_held > 0) begin
        piv = clamp32(piv - fx_mul(lower_coeff_i, sweep_upper[rows_held-1]));
        num = clamp32(num - fx_mul(lower_coeff_i, sweep_rhs[rows_held-1]));
      end
      if (piv == 0) pivot_zero = 1'b1;
      sweep_upper[rows_held] = fx_div(upper_coeff_i, piv);
      sweep_rhs[rows_held] = fx_div(num, piv);
      rows_held++;
    end else begin
      rows_dropped = 1'b1;
    end
    if (!last_row_i) return;
    st = rows_dropped ? StatusOverflow : (pivot_zero ? StatusZeroPiv : StatusOk);
    x = 0;
    for (int i = rows_held - 1; i >= 0; i--) begin
      if (i == rows_held - 1) x = sweep_rhs[i];
      else x = clamp32(sweep_rhs[i] - fx_mul(sweep_upper[i], x));
      solution_q.push_back('{x[31:0], 6'(i), i == 0, st});
    end
    rows_held = 0;
    pivot_zero = 1'b0;
    rows_dropped = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    solutions_pending = 0;
    rows_held = 0;
    pivot_zero = 1'b0;
    rows_dropped = 1'b0;
  end

  always @(posedge clk_i) begin
    solution_t want;
    if (rst_ni) begin
      if (!empty && pop) begin
        if (solution_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected solution beat row %0d value %0d", $time,
                   row_index_o, solution_value_o);
        end else begin
          want = solution_q.pop_front();
          if (want.value !== solution_value_o) begin
            fail_count++;
            $display("%0t: solution_value expected %0d actual %0d", $time,
                     want.value, solution_value_o);
          end
          if (want.row !== row_index_o) begin
            fail_count++;
            $display("%0t: row_index expected %0d actual %0d", $time,
                     want.row, row_index_o);
          end
          if (want.fin !== final_result_o) begin
            fail_count++;
            $display("%0t: final_result expected %0d actual %0d", $time,
                     want.fin, final_result_o);
          end
          if (want.status !== status_o) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, status_o);
          end
        end
      end
      if (push && !full) sweep_row();
    end
    solutions_pending = solution_q.size();
  end
endmodule

[verif/tridiagonal_system_solver_test.sv]
module tridiagonal_system_solver_test import tds_pkg::*;;
  logic               clk_i, rst_ni, push, pop;
  logic               full, empty;
  logic signed [31:0] lower_coeff_i, main_coeff_i, upper_coeff_i, rhs_value_i;
  logic               last_row_i;
  logic signed [31:0] solution_value_o;
  logic [5:0]         row_index_o;
  logic               final_result_o;
  logic [1:0]         status_o;
  int                 fail_count, solutions_pending;
  int                 cycles, send_idle, recv_idle;
  logic               stim_done;

  tridiagonal_system_solver uut (.*);
  tridiagonal_system_solver_checker chk (.*);

  localparam int CycleLimit = 3000000;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) pop <= rst_ni && ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] any_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // diagonally dominant-ish so the sweep stays meaningful
  function automatic logic signed [31:0] coeff();
    return $signed($urandom_range(32'h3ffff)) - 32'sh1ffff;
  endfunction

  task automatic send_row(input logic signed [31:0] a, b, c, d, input logic l);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    lower_coeff_i <= a;
    main_coeff_i <= b;
    upper_coeff_i <= c;
    rhs_value_i <= d;
    last_row_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_system(input int n, input bit wild);
    for (int i = 0; i < n; i++) begin
      if (wild)
        send_row(any_word(), any_word(), any_word(), any_word(), i == n - 1);
      else
        send_row(coeff(), $signed(32'h40000) + coeff(), coeff(), any_word(), i == n - 1);
    end
  endtask

  initial begin
    cycles = 0;
    stim_done = 1'b0;
    send_idle = 12;
    recv_idle = 64;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    {lower_coeff_i, main_coeff_i, upper_coeff_i, rhs_value_i, last_row_i} = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: single row, zero pivot, extremes, overflow with dropped last row
    send_row(0, 32'h10000, 0, 32'h30000, 1'b1);
    send_row(32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 1'b0);
    send_row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1);
    send_row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b0);
    send_row(32'h7fffffff, 32'h1, 32'h7fffffff, 32'h80000000, 1'b1);
    send_system(4, 1'b1);
    send_system(MaxRows + 3, 1'b0);
    send_system(MaxRows, 1'b1);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 12 : (phase == 1 ? 64 : 0);
      recv_idle = phase == 0 ? 64 : (phase == 1 ? 12 : 0);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(9) == 0) send_system($urandom_range(1, 3), 1'b1);
        else send_system($urandom_range(1, 10), 1'b0);
      end
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (solutions_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && solutions_pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
